// ----- rtl/core/fnm_pkg.sv -----
// shared types and constants of the filtered noise mixer
package fnm_pkg;

    localparam int SAMPLE_IN_W  = 24;
    localparam int SAMPLE_OUT_W = 32;
    localparam int CFG_INDEX_W  = 8;
    localparam int CFG_DATA_W   = 32;

    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    // items that can be in flight: queue, back end and output register
    localparam int MAX_OUTSTANDING = QUEUE_DEPTH + 2;
    localparam int OUTST_W         = $clog2(MAX_OUTSTANDING + 1);

    localparam int MUL_W  = 33;
    localparam int PROD_W = 47;
    localparam int Q_SHIFT   = 15;
    localparam int VOL_SHIFT = 7;
    localparam int GAIN_SHIFT = 3;

    localparam logic [31:0] LCG_MUL        = 32'd196314165;
    localparam logic [31:0] LCG_ADD        = 32'd907633515;
    localparam logic [31:0] LCG_SEED_RESET = 32'd22222;
    localparam logic signed [SAMPLE_IN_W-1:0] CLAMP_HI = 24'sd4096;
    localparam logic signed [SAMPLE_IN_W-1:0] CLAMP_LO = -24'sd4096;

    localparam logic [CFG_INDEX_W-1:0] REG_BYPASS  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_VOLUME  = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_B0 = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_B2 = 8'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_A1 = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_A2 = 8'd5;

    typedef struct packed {
        logic               bypass;
        logic [7:0]         volume;
        logic signed [15:0] coef_b0;
        logic signed [15:0] coef_b2;
        logic signed [16:0] coef_a1;
        logic signed [15:0] coef_a2;
    } fnm_cfg_t;

    typedef struct packed {
        logic [SAMPLE_OUT_W-1:0] acc;
        logic                    noise_en;
    } fnm_entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LCG,
        ST_B2,
        ST_B0,
        ST_A1,
        ST_A2,
        ST_SUM,
        ST_VOL,
        ST_DONE
    } fnm_state_t;

endpackage

// ----- rtl/core/fnm_front.sv -----
// front end: configuration registers, sample conditioning and queue push
module fnm_front import fnm_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [SAMPLE_IN_W-1:0]   s_axis_tdata,
    output logic                     push_valid,
    input  logic                     push_ready,
    output fnm_entry_t               push_entry,
    output fnm_cfg_t                 cfg
);

    fnm_cfg_t cfg_reg;
    logic signed [SAMPLE_IN_W-1:0] s_in;
    logic signed [SAMPLE_IN_W-1:0] s_clamped;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bypass  <= 1'b0;
            cfg_reg.volume  <= 8'd128;
            cfg_reg.coef_b0 <= '0;
            cfg_reg.coef_b2 <= '0;
            cfg_reg.coef_a1 <= '0;
            cfg_reg.coef_a2 <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_BYPASS:  cfg_reg.bypass  <= cfg_data[0];
                REG_VOLUME:  cfg_reg.volume  <= cfg_data[7:0];
                REG_COEF_B0: cfg_reg.coef_b0 <= cfg_data[15:0];
                REG_COEF_B2: cfg_reg.coef_b2 <= cfg_data[15:0];
                REG_COEF_A1: cfg_reg.coef_a1 <= cfg_data[16:0];
                REG_COEF_A2: cfg_reg.coef_a2 <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        s_in = s_axis_tdata;
        if (s_in > CLAMP_HI) begin
            s_clamped = CLAMP_HI;
        end else if (s_in < CLAMP_LO) begin
            s_clamped = CLAMP_LO;
        end else begin
            s_clamped = s_in;
        end
        if (cfg_reg.bypass) begin
            push_entry.acc = {{(SAMPLE_OUT_W-SAMPLE_IN_W){s_in[SAMPLE_IN_W-1]}}, s_in};
        end else begin
            push_entry.acc = {{(SAMPLE_OUT_W-SAMPLE_IN_W-GAIN_SHIFT){s_clamped[SAMPLE_IN_W-1]}},
                              s_clamped, {GAIN_SHIFT{1'b0}}};
        end
        // noise items go through the filter sequence, others skip it
        push_entry.noise_en = (cfg_reg.volume != 8'd0);
    end

    assign push_valid    = s_axis_tvalid;
    assign s_axis_tready = push_ready;

endmodule

// ----- rtl/core/fnm_queue.sv -----
// short item queue between front and back end
module fnm_queue import fnm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push_valid,
    output logic        push_ready,
    input  fnm_entry_t  push_entry,
    output logic        pop_valid,
    input  logic        pop_ready,
    output fnm_entry_t  pop_entry
);

    fnm_entry_t        q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != QUEUE_DEPTH[QPTR_W:0]);
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = q_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            q_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- rtl/core/fnm_back.sv -----
// back end: noise generator and biquad on one shared multiplier, output register
module fnm_back import fnm_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  fnm_cfg_t                cfg,
    input  logic                    pop_valid,
    output logic                    pop_ready,
    input  fnm_entry_t              pop_entry,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [SAMPLE_OUT_W-1:0] m_axis_tdata
);

    fnm_state_t state_reg, state_next;

    logic [31:0]        acc_reg, acc_next;
    logic               noise_reg, noise_next;
    logic [31:0]        seed_reg, seed_next;
    logic signed [15:0] np1_reg, np1_next;
    logic signed [15:0] np2_reg, np2_next;
    logic [31:0]        f1_reg, f1_next;
    logic [31:0]        f2_reg, f2_next;
    logic [31:0]        sum_reg, sum_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [31:0]        out_data_reg, out_data_next;
    logic               out_valid_reg, out_valid_next;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] mul_full;
    logic [31:0]               q_term;
    logic [31:0]               vol_term;
    logic                      out_free;
    logic                      take;

    assign mul_full = mul_a * mul_b;
    assign q_term   = prod_reg[Q_SHIFT +: 32];
    assign vol_term = prod_reg[VOL_SHIFT +: 32];
    assign out_free = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        noise_next     = noise_reg;
        seed_next      = seed_reg;
        np1_next       = np1_reg;
        np2_next       = np2_reg;
        f1_next        = f1_reg;
        f2_next        = f2_reg;
        sum_next       = sum_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        mul_a          = '0;
        mul_b          = '0;
        take           = 1'b0;
        pop_ready      = 1'b0;

        if (out_valid_reg && m_axis_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                take = 1'b1;
            end
            ST_LCG: begin
                mul_a = {1'b0, seed_reg};
                mul_b = {1'b0, LCG_MUL};
                state_next = ST_B2;
            end
            ST_B2: begin
                seed_next = prod_reg[31:0] + LCG_ADD;
                mul_a = MUL_W'(cfg.coef_b2);
                mul_b = MUL_W'(np2_reg);
                state_next = ST_B0;
            end
            ST_B0: begin
                sum_next = q_term;
                mul_a = MUL_W'(cfg.coef_b0);
                mul_b = MUL_W'($signed(seed_reg[31:16]));
                state_next = ST_A1;
            end
            ST_A1: begin
                sum_next = sum_reg + q_term;
                mul_a = MUL_W'(cfg.coef_a1);
                mul_b = MUL_W'($signed(f1_reg));
                state_next = ST_A2;
            end
            ST_A2: begin
                sum_next = sum_reg - q_term;
                mul_a = MUL_W'(cfg.coef_a2);
                mul_b = MUL_W'($signed(f2_reg));
                state_next = ST_SUM;
            end
            ST_SUM: begin
                sum_next = sum_reg - q_term;
                state_next = ST_VOL;
            end
            ST_VOL: begin
                mul_a = MUL_W'($signed(sum_reg));
                mul_b = {{(MUL_W-8){1'b0}}, cfg.volume};
                np2_next = np1_reg;
                np1_next = seed_reg[31:16];
                f2_next  = f1_reg;
                f1_next  = sum_reg;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = noise_reg ? acc_reg + vol_term : acc_reg;
                    take = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // next item starts straight from idle or from a finished item
        if (take) begin
            pop_ready = 1'b1;
            if (pop_valid) begin
                acc_next   = pop_entry.acc;
                noise_next = pop_entry.noise_en;
                state_next = pop_entry.noise_en ? ST_LCG : ST_DONE;
            end else begin
                state_next = ST_IDLE;
            end
        end

        // the volume product waits here while the output is stalled
        prod_next = (state_reg == ST_DONE) ? prod_reg : mul_full[PROD_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            seed_reg      <= LCG_SEED_RESET;
            np1_reg       <= '0;
            np2_reg       <= '0;
            f1_reg        <= '0;
            f2_reg        <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            seed_reg      <= seed_next;
            np1_reg       <= np1_next;
            np2_reg       <= np2_next;
            f1_reg        <= f1_next;
            f2_reg        <= f2_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg      <= acc_next;
        noise_reg    <= noise_next;
        sum_reg      <= sum_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ----- rtl/core/filtered_noise_mixer.sv -----
// top level of the filtered noise mixer
// Each audio sample is clamped to +/-4096 and scaled by 8 (or passed as is
// when bypass is set), then band-pass filtered noise from a 32-bit LCG,
// scaled by volume/128, is added; the sum wraps at 32 bits. Volume zero
// freezes the generator and filter and adds nothing. In the back end a
// noise item's sequencer issues the LCG step, four filter products and
// the volume product through one shared 33x33 multiplier; with noise off
// an item goes straight to its output step there. A two-item queue
// lets the input keep accepting while the back end works, and the output
// register lets the next item start while a result waits to be taken.
// Configuration is accepted every cycle and should be written while idle.
module filtered_noise_mixer import fnm_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [SAMPLE_IN_W-1:0]  s_axis_tdata,   // [23:0] sample_in
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [SAMPLE_OUT_W-1:0] m_axis_tdata    // [31:0] sample_out
);

    fnm_cfg_t   cfg;
    fnm_entry_t push_entry, pop_entry;
    logic       push_valid, push_ready;
    logic       pop_valid, pop_ready;

    fnm_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_entry    (push_entry),
        .cfg           (cfg)
    );

    fnm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    fnm_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_entry     (pop_entry),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ----- rtl/core/fnm_checker.sv -----
// port-level checks of the filtered noise mixer and their bind
module fnm_checker import fnm_pkg::*; (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    cfg_valid,
    input logic                    cfg_ready,
    input logic                    s_axis_tvalid,
    input logic                    s_axis_tready,
    input logic                    m_axis_tvalid,
    input logic                    m_axis_tready,
    input logic [SAMPLE_OUT_W-1:0] m_axis_tdata
);

    logic [OUTST_W-1:0] outst_reg, outst_next;
    logic               in_acc, out_acc;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    always_comb begin
        outst_next = outst_reg;
        if (in_acc && !out_acc) begin
            outst_next = outst_reg + 1'b1;
        end else if (out_acc && !in_acc) begin
            outst_next = outst_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outst_reg <= '0;
        end else begin
            outst_reg <= outst_next;
        end
    end

    // a result only for an item that was taken in
    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc |-> (outst_reg != '0))
        else $error("result without a pending item");

    // the pipeline never holds more items than it has room for
    a_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (outst_reg == OUTST_W'(MAX_OUTSTANDING)) |-> !s_axis_tready)
        else $error("input accepted with the pipeline full");

    // a stalled result keeps its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    // no result shows up in the cycle after reset
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // configuration is never refused
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind filtered_noise_mixer fnm_checker u_fnm_checker (.*);

// ----- tb/sv/tb_filtered_noise_mixer.sv -----
`timescale 1ns / 100ps
// self-checking testbench of the filtered noise mixer: directed and random samples
module tb_filtered_noise_mixer;
    import fnm_pkg::*;

    localparam int TOTAL_ITEMS = 1700;
    localparam int QUIET_TAIL  = 200;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_BACKLOG = 16;
    localparam int MAX_PRINTS  = 40;
    localparam int SETTLE      = 12;

    // register indexes the block does not decode
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LO = 8'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HI = 8'hFF;

    logic                    aclk          = 1'b0;
    logic                    aresetn       = 1'b0;
    logic                    cfg_valid     = 1'b0;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0]   cfg_data      = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [SAMPLE_IN_W-1:0]  s_axis_tdata  = '0;   // [23:0] sample_in
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [SAMPLE_OUT_W-1:0] m_axis_tdata;         // [31:0] sample_out

    filtered_noise_mixer DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    logic [SAMPLE_IN_W-1:0]  pending_samples[$];
    logic [SAMPLE_OUT_W-1:0] expected_out[$];

    // shadow registers and mixer state
    logic               byp_r;
    logic [7:0]         vol_r;
    logic signed [15:0] b0_r;
    logic signed [15:0] b2_r;
    logic signed [16:0] a1_r;
    logic signed [15:0] a2_r;
    logic [31:0]        gen_seed;
    logic signed [15:0] noise_d1;
    logic signed [15:0] noise_d2;
    logic signed [31:0] filt_d1;
    logic signed [31:0] filt_d2;

    int   src_idle_pct    = 0;
    int   sink_idle_pct   = 0;
    int   src_gap         = 0;
    int   sink_gap        = 0;
    logic sink_hold       = 1'b0;
    int   items_accepted  = 0;
    int   results_checked = 0;
    int   quiet_items     = 0;
    int   settings_used   = 0;
    int   mismatches      = 0;

    task automatic report_mismatch(input string what);
        if (mismatches < MAX_PRINTS) begin
            $display("mismatch at %0t ns: %s", $time, what);
        end
        mismatches++;
    endtask

    task automatic reset_mixer_model();
        byp_r    = 1'b0;
        vol_r    = 8'd128;
        b0_r     = '0;
        b2_r     = '0;
        a1_r     = '0;
        a2_r     = '0;
        gen_seed = LCG_SEED_RESET;
        noise_d1 = '0;
        noise_d2 = '0;
        filt_d1  = '0;
        filt_d2  = '0;
    endtask

    task automatic apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_BYPASS:  byp_r = data[0];
            REG_VOLUME:  vol_r = data[7:0];
            REG_COEF_B0: b0_r  = data[15:0];
            REG_COEF_B2: b2_r  = data[15:0];
            REG_COEF_A1: a1_r  = data[16:0];
            REG_COEF_A2: a2_r  = data[15:0];
            default: ;
        endcase
    endtask

    // exact product, floor shift
    function automatic longint q15_term(input longint coef, input longint val);
        longint prod;
        prod = coef * val;
        return prod >>> Q_SHIFT;
    endfunction

    function automatic logic [SAMPLE_OUT_W-1:0] mix_sample(input logic [SAMPLE_IN_W-1:0] raw);
        int                 smp;
        logic [31:0]        acc;
        logic signed [15:0] n0;
        longint             filt_sum;
        logic signed [31:0] y;
        longint             noise_add;
        smp = $signed(raw);
        if (byp_r) begin
            acc = smp;
        end else begin
            if (smp > 4096) smp = 4096;
            if (smp < -4096) smp = -4096;
            acc = smp << GAIN_SHIFT;
        end
        if (vol_r != 8'd0) begin
            gen_seed = gen_seed * LCG_MUL + LCG_ADD;
            n0 = gen_seed[31:16];
            filt_sum = q15_term(b0_r, n0) + q15_term(b2_r, noise_d2)
                     - q15_term(a1_r, filt_d1) - q15_term(a2_r, filt_d2);
            y = filt_sum[31:0];
            noise_d2 = noise_d1;
            noise_d1 = n0;
            filt_d2  = filt_d1;
            filt_d1  = y;
            noise_add = longint'(y) * longint'({24'd0, vol_r});
            noise_add = noise_add >>> VOL_SHIFT;
            acc = acc + noise_add[31:0];
        end else begin
            quiet_items++;
        end
        return acc;
    endfunction

    function automatic logic [SAMPLE_IN_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 24'($urandom());
            1: begin
                case ($urandom_range(0, 5))
                    0: return 24'h7FFFFF;
                    1: return 24'h800000;
                    2: return 24'(4096);
                    3: return 24'(4097);
                    4: return 24'(-4096);
                    default: return 24'(-4097);
                endcase
            end
            2, 3, 4, 5: return 24'(int'($urandom_range(0, 12000)) - 6000);
            default: return 24'(int'($urandom_range(0, 8192)) - 4096);
        endcase
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 5;
            2: return 20;
            default: return 50;
        endcase
    endfunction

    // input side: offers items from the pending queue, with random gaps
    always @(posedge aclk) begin : source_drive
        logic offer;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_out.push_back(mix_sample(s_axis_tdata));
                items_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                offer = 1'b0;
                if (src_gap > 0) begin
                    src_gap--;
                end else if (pending_samples.size() != 0) begin
                    if ($urandom_range(0, 99) < src_idle_pct) begin
                        src_gap = $urandom_range(0, 13);
                    end else begin
                        s_axis_tdata <= pending_samples.pop_front();
                        offer = 1'b1;
                    end
                end
                s_axis_tvalid <= offer;
            end
        end
    end

    // output side: random stall bursts, plus the long hold
    always @(posedge aclk) begin : sink_drive
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            sink_gap = 0;
        end else if (sink_hold) begin
            m_axis_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < sink_idle_pct) begin
            sink_gap = $urandom_range(0, 13);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : result_check
        logic [SAMPLE_OUT_W-1:0] want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_out.size() == 0) begin
                report_mismatch($sformatf("unexpected sample_out %08h", m_axis_tdata));
            end else begin
                want = expected_out.pop_front();
                if (m_axis_tdata !== want) begin
                    report_mismatch($sformatf("item %0d sample_out %08h, want %08h",
                                              results_checked, m_axis_tdata, want));
                end
                results_checked++;
            end
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_reg(idx, data);
    endtask

    // wait until every offered item has come back out
    task automatic drain();
        do @(negedge aclk);
        while (pending_samples.size() != 0 || s_axis_tvalid || expected_out.size() != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic random_setting();
        logic [31:0] r;
        int          g;
        r = $urandom();
        r[0] = ($urandom_range(0, 3) == 0);
        write_reg(REG_BYPASS, r);
        r = $urandom();
        case ($urandom_range(0, 7))
            0: r[7:0] = 8'd0;
            1: r[7:0] = 8'd128;
            2: r[7:0] = 8'd255;
            3: r[7:0] = 8'd1;
            4: r[7:0] = 8'($urandom_range(129, 255));
            default: r[7:0] = 8'($urandom_range(1, 128));
        endcase
        write_reg(REG_VOLUME, r);
        if ($urandom_range(0, 1) == 0) begin
            // arbitrary coefficients, junk above the field
            write_reg(REG_COEF_B0, $urandom());
            write_reg(REG_COEF_B2, $urandom());
            write_reg(REG_COEF_A1, $urandom());
            write_reg(REG_COEF_A2, $urandom());
        end else begin
            // band-pass shape: b2 = -b0, a2 positive and below one
            g = $urandom_range(0, 16000);
            write_reg(REG_COEF_B0, 32'(g));
            write_reg(REG_COEF_B2, 32'(-g));
            write_reg(REG_COEF_A1, 32'(int'($urandom_range(0, 120000)) - 60000));
            write_reg(REG_COEF_A2, 32'($urandom_range(16000, 32000)));
        end
        if ($urandom_range(0, 4) == 0) begin
            write_reg(8'($urandom_range(6, 255)), $urandom());
        end
        settings_used++;
    endtask

    initial begin : stimulus
        int n;
        reset_mixer_model();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // reset setting: coefficients zero, generator still runs
        @(negedge aclk);
        pending_samples = {24'h000000, 24'h7FFFFF, 24'h800000, 24'h000064};
        settings_used++;
        drain();

        // clamp edges, volume above unity
        write_reg(REG_BYPASS, 32'd0);
        write_reg(REG_VOLUME, 32'd255);
        write_reg(REG_COEF_B0, 32'(12000));
        write_reg(REG_COEF_B2, 32'(-12000));
        write_reg(REG_COEF_A1, 32'(-52000));
        write_reg(REG_COEF_A2, 32'(28000));
        settings_used++;
        @(negedge aclk);
        pending_samples = {24'h001000, 24'h001001, 24'hFFF000, 24'hFFEFFF,
                           24'h000001, 24'hFFFFFF, 24'h555555, 24'hAAAAAA};
        drain();

        // bypass with noise frozen
        write_reg(REG_BYPASS, 32'hFFFF_FFFF);
        write_reg(REG_VOLUME, 32'hFFFF_FF00);
        settings_used++;
        @(negedge aclk);
        pending_samples = {24'h7FFFFF, 24'h800000, 24'h555555, 24'hAAAAAA, 24'h003039};
        drain();

        // coefficient extremes, writes to undecoded indexes
        write_reg(REG_BYPASS, 32'hFFFF_FFFE);
        write_reg(REG_VOLUME, 32'd1);
        write_reg(REG_COEF_B0, 32'(-32768));
        write_reg(REG_COEF_B2, 32'(32767));
        write_reg(REG_COEF_A1, 32'(-65536));
        write_reg(REG_COEF_A2, 32'(-32768));
        write_reg(REG_UNUSED_LO, 32'hFFFF_FFFF);
        write_reg(REG_UNUSED_HI, 32'hFFFF_FFFF);
        settings_used++;
        @(negedge aclk);
        pending_samples = {24'h7FFFFF, 24'h800000, 24'h000000, 24'h000FFF};
        drain();

        write_reg(REG_VOLUME, 32'd128);
        write_reg(REG_COEF_B0, 32'(32767));
        write_reg(REG_COEF_B2, 32'(-32768));
        write_reg(REG_COEF_A1, 32'(65535));
        write_reg(REG_COEF_A2, 32'(32767));
        settings_used++;
        @(negedge aclk);
        pending_samples = {24'h001000, 24'hFFF000, 24'h7FFFFF, 24'h800000};
        drain();

        while (items_accepted < TOTAL_ITEMS) begin
            random_setting();
            n = $urandom_range(20, 150);
            @(negedge aclk);
            if (items_accepted > TOTAL_ITEMS - QUIET_TAIL) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end else begin
                src_idle_pct  = pick_pct();
                sink_idle_pct = pick_pct();
            end
            repeat (n) pending_samples.push_back(pick_sample());
            drain();
        end

        $display("checked %0d results over %0d register settings, %0d items with noise off",
                 results_checked, settings_used, quiet_items);
        $display("output held off for %0d cycles while input kept offering", HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // back-pressure long enough to fill the queue and stall the input
    initial begin : output_hold
        int held;
        do @(posedge aclk);
        while (items_accepted < HOLD_AT || pending_samples.size() < HOLD_BACKLOG);
        sink_hold <= 1'b1;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge aclk);
        sink_hold <= 1'b0;
    end

    initial begin : watchdog
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
